### rtl/complex_phase_angle_assert.svh
// Assertion macros shared by the phase angle pipeline.
// Each use names a label and the property terms; clk and rst_n come from the module.
`ifndef COMPLEX_PHASE_ANGLE_ASSERT_SVH
`define COMPLEX_PHASE_ANGLE_ASSERT_SVH

`ifndef SYNTH

// A condition that must hold at every edge out of reset.
`define CPA_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("phase angle pipeline check failed");

// A consequence that must hold in the cycle after the antecedent.
`define CPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("phase angle pipeline check failed");

`else

`define CPA_ASSERT(lbl, cond)
`define CPA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/cpa_pkg.sv
package cpa_pkg;

  // Defaults for the top level parameters.
  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CORDIC_STAGES_DEF   = 16;

  // Growth room for x and y: left half-plane negation and the CORDIC gain.
  localparam int XY_GUARD = 3;

  // Angle accumulator in binary angle units, 2^32 per turn, with headroom.
  localparam int ZW = 34;
  localparam logic signed [ZW-1:0] HALF_TURN = 34'sh0_8000_0000;

  // pi * 2^29, rounded.
  localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;

  // Result phase width.
  localparam int PHASE_W = 16;

  // Tag that travels with every sample through the pipeline.
  typedef struct packed {
    logic zero;
    logic last;
  } cpa_tag_t;

  // atan(2^-i) in binary angle units, rounded to nearest.
  function automatic logic [31:0] stage_angle(input int unsigned idx);
    logic [31:0] a;
    case (idx)
      0:       a = 32'h2000_0000;
      1:       a = 32'h12E4_051E;
      2:       a = 32'h09FB_385B;
      3:       a = 32'h0511_11D4;
      4:       a = 32'h028B_0D43;
      5:       a = 32'h0145_D7E1;
      6:       a = 32'h00A2_F61E;
      7:       a = 32'h0051_7C55;
      8:       a = 32'h0028_BE53;
      9:       a = 32'h0014_5F2F;
      10:      a = 32'h000A_2F98;
      11:      a = 32'h0005_17CC;
      12:      a = 32'h0002_8BE6;
      13:      a = 32'h0001_45F3;
      14:      a = 32'h0000_A2FA;
      15:      a = 32'h0000_517D;
      16:      a = 32'h0000_28BE;
      17:      a = 32'h0000_145F;
      18:      a = 32'h0000_0A30;
      19:      a = 32'h0000_0518;
      20:      a = 32'h0000_028C;
      21:      a = 32'h0000_0146;
      22:      a = 32'h0000_00A3;
      23:      a = 32'h0000_0051;
      24:      a = 32'h0000_0029;
      25:      a = 32'h0000_0014;
      26:      a = 32'h0000_000A;
      27:      a = 32'h0000_0005;
      28:      a = 32'h0000_0003;
      29:      a = 32'h0000_0001;
      30:      a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

### rtl/cpa_prerot.sv
module cpa_prerot #(
  parameter int SAMPLE_WIDTH = cpa_pkg::SAMPLE_WIDTH_DEF,
  localparam int XW = SAMPLE_WIDTH + cpa_pkg::XY_GUARD
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_re,
  input  logic signed [SAMPLE_WIDTH-1:0] in_im,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [XW-1:0]          out_x,
  output logic signed [XW-1:0]          out_y,
  output logic signed [cpa_pkg::ZW-1:0] out_z,
  output cpa_pkg::cpa_tag_t             out_tag
);
  import cpa_pkg::*;

  logic signed [XW-1:0] x_ext, y_ext;
  logic signed [XW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;
  cpa_tag_t             tag_nxt;
  logic                 valid_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  cpa_tag_t             tag_r;

  // Sign extend, flag the zero sample and turn the left half-plane by pi.
  always_comb begin
    x_ext = XW'(in_re);
    y_ext = XW'(in_im);
    tag_nxt.zero = (x_ext == '0) && (y_ext == '0);
    tag_nxt.last = in_last;
    if (x_ext[XW-1]) begin
      x_nxt = -x_ext;
      y_nxt = -y_ext;
      z_nxt = y_ext[XW-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      x_nxt = x_ext;
      y_nxt = y_ext;
      z_nxt = '0;
    end
  end

  assign in_ready = !valid_r || out_ready;

  // Stage register; a beat moves in whenever the slot is free or draining.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      tag_r <= tag_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_tag   = tag_r;

endmodule

### rtl/cpa_stage.sv
module cpa_stage #(
  parameter int SAMPLE_WIDTH = cpa_pkg::SAMPLE_WIDTH_DEF,
  parameter int STAGE_IDX    = 0,
  localparam int XW = SAMPLE_WIDTH + cpa_pkg::XY_GUARD
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [XW-1:0]          in_x,
  input  logic signed [XW-1:0]          in_y,
  input  logic signed [cpa_pkg::ZW-1:0] in_z,
  input  cpa_pkg::cpa_tag_t             in_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [XW-1:0]          out_x,
  output logic signed [XW-1:0]          out_y,
  output logic signed [cpa_pkg::ZW-1:0] out_z,
  output cpa_pkg::cpa_tag_t             out_tag
);
  import cpa_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = ZW'(stage_angle(STAGE_IDX));

  logic signed [XW-1:0] xs, ys;
  logic signed [XW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic                 valid_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  cpa_tag_t             tag_r;

  // One vectoring micro-rotation toward the positive real axis.
  always_comb begin
    xs = in_x >>> STAGE_IDX;
    ys = in_y >>> STAGE_IDX;
    if (!in_y[XW-1]) begin
      x_nxt = in_x + ys;
      y_nxt = in_y - xs;
      z_nxt = in_z + ANGLE;
    end else begin
      x_nxt = in_x - ys;
      y_nxt = in_y + xs;
      z_nxt = in_z - ANGLE;
    end
  end

  assign in_ready = !valid_r || out_ready;

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      tag_r <= in_tag;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_tag   = tag_r;

endmodule

### rtl/cpa_convert.sv
module cpa_convert #(
  parameter int ANGLE_FRAC_BITS = cpa_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [cpa_pkg::ZW-1:0]      in_z,
  input  cpa_pkg::cpa_tag_t                  in_tag,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [cpa_pkg::PHASE_W-1:0] out_phase,
  output cpa_pkg::cpa_tag_t                  out_tag
);
  import cpa_pkg::*;

  `include "complex_phase_angle_assert.svh"

  // Binary angle times pi*2^29 carries 60 fraction bits.
  localparam int SHIFT = 60 - ANGLE_FRAC_BITS;
  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (SHIFT - 1);

  logic signed [ZW-1:0]      zc_full;
  logic signed [ZW-2:0]      zc_nxt;
  logic signed [63:0]        prod_nxt;
  logic signed [63:0]        sum;
  logic signed [63:0]        shifted;
  logic signed [PHASE_W-1:0] phase_nxt;

  logic                      val_a_r, val_b_r, val_c_r;
  logic                      rdy_a, rdy_b, rdy_c;
  logic signed [ZW-2:0]      zc_r;
  logic signed [63:0]        prod_r;
  logic signed [PHASE_W-1:0] phase_r;
  cpa_tag_t                  tag_a_r, tag_b_r, tag_c_r;

  // Ready chain: a slot takes a beat when empty or when its successor drains.
  assign rdy_c    = !val_c_r || out_ready;
  assign rdy_b    = !val_b_r || rdy_c;
  assign rdy_a    = !val_a_r || rdy_b;
  assign in_ready = rdy_a;

  // Clamp the residual angle to the closed range -pi..pi.
  always_comb begin
    if (in_z > HALF_TURN) begin
      zc_full = HALF_TURN;
    end else if (in_z < -HALF_TURN) begin
      zc_full = -HALF_TURN;
    end else begin
      zc_full = in_z;
    end
    zc_nxt = zc_full[ZW-2:0];
  end

  // Scale to radians, then round half up and drop the extra fraction bits.
  assign prod_nxt  = zc_r * PI_Q29;
  assign sum       = prod_r + ROUND_HALF;
  assign shifted   = sum >>> SHIFT;
  assign phase_nxt = tag_b_r.zero ? '0 : shifted[PHASE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_a_r <= 1'b0;
      val_b_r <= 1'b0;
      val_c_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        val_a_r <= in_valid;
      end
      if (rdy_b) begin
        val_b_r <= val_a_r;
      end
      if (rdy_c) begin
        val_c_r <= val_b_r;
      end
    end
    if (in_valid && rdy_a) begin
      zc_r    <= zc_nxt;
      tag_a_r <= in_tag;
    end
    if (val_a_r && rdy_b) begin
      prod_r  <= prod_nxt;
      tag_b_r <= tag_a_r;
    end
    if (val_b_r && rdy_c) begin
      phase_r <= phase_nxt;
      tag_c_r <= tag_b_r;
    end
  end

  assign out_valid = val_c_r;
  assign out_phase = phase_r;
  assign out_tag   = tag_c_r;

  // The clamped angle never leaves -pi..pi.
  `CPA_ASSERT(a_clamp_range, !val_a_r || (zc_r <= HALF_TURN && zc_r >= -HALF_TURN))
  // A zero sample always leaves with phase zero.
  `CPA_ASSERT(a_zero_phase, !val_c_r || !tag_c_r.zero || phase_r == '0)
  // A product blocked by a full output slot stays in place.
  `CPA_ASSERT_NEXT(a_prod_hold, val_b_r && !rdy_c, val_b_r && $stable(prod_r))

endmodule

### rtl/complex_phase_angle.sv
// Phase angle of a complex sample, atan2(im, re), in the closed range -pi..pi.
// Input channel: in_valid/in_ready with in_sample_re, in_sample_im (signed,
// SAMPLE_WIDTH bits) and in_last_in. Output channel: out_valid/out_ready with
// out_phase (signed 16-bit radians, ANGLE_FRAC_BITS fraction bits, pi = 25736
// at 13) and out_last_out, a copy of the input flag.
// The path is registered: one pre-rotation stage, one register per
// CORDIC micro-rotation, then clamp, multiply by pi and rounding stages.
// Throughput is one beat per cycle while the receiver does not stall; every
// stage is a shift-add or a single 33 by 32 multiply between registers.
// A sample that is exactly zero returns phase 0; one on the negative real
// axis returns +pi.
// Reset empties the pipeline; no results are pending afterwards.
// Each stage holds its own valid bit, so when the receiver stalls the beats
// pack up behind the output register, and in_ready drops only once every
// stage is full. Nothing is lost or repeated under a stall.
module complex_phase_angle #(
  parameter int SAMPLE_WIDTH    = cpa_pkg::SAMPLE_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = cpa_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = cpa_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample_im,
  input  logic                               in_last_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [cpa_pkg::PHASE_W-1:0] out_phase,
  output logic                               out_last_out
);
  import cpa_pkg::*;

  localparam int XW = SAMPLE_WIDTH + XY_GUARD;

  // Stage k drives slot k+1; slot 0 is the pre-rotation output.
  logic                 valid_s [CORDIC_STAGES+1];
  logic                 ready_s [CORDIC_STAGES+1];
  logic signed [XW-1:0] x_s     [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_s     [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_s     [CORDIC_STAGES+1];
  cpa_tag_t             tag_s   [CORDIC_STAGES+1];
  cpa_tag_t             out_tag;

  // Sign extension, zero detect and left half-plane turn.
  cpa_prerot #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_prerot (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_re    (in_sample_re),
    .in_im    (in_sample_im),
    .in_last  (in_last_in),
    .out_valid(valid_s[0]),
    .out_ready(ready_s[0]),
    .out_x    (x_s[0]),
    .out_y    (y_s[0]),
    .out_z    (z_s[0]),
    .out_tag  (tag_s[0])
  );

  // CORDIC vectoring chain, one registered micro-rotation per stage.
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    cpa_stage #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .STAGE_IDX   (k)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (valid_s[k]),
      .in_ready (ready_s[k]),
      .in_x     (x_s[k]),
      .in_y     (y_s[k]),
      .in_z     (z_s[k]),
      .in_tag   (tag_s[k]),
      .out_valid(valid_s[k+1]),
      .out_ready(ready_s[k+1]),
      .out_x    (x_s[k+1]),
      .out_y    (y_s[k+1]),
      .out_z    (z_s[k+1]),
      .out_tag  (tag_s[k+1])
    );
  end

  // Clamp, scale to radians and round.
  cpa_convert #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_convert (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (valid_s[CORDIC_STAGES]),
    .in_ready (ready_s[CORDIC_STAGES]),
    .in_z     (z_s[CORDIC_STAGES]),
    .in_tag   (tag_s[CORDIC_STAGES]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_phase(out_phase),
    .out_tag  (out_tag)
  );

  assign out_last_out = out_tag.last;

endmodule

### tb/cpa_checker.sv
// Watches both channels of the phase angle block, predicts each result
// and compares it with the beat that comes out.
module cpa_checker #(
  parameter int SAMPLE_WIDTH    = cpa_pkg::SAMPLE_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = cpa_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = cpa_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample_im,
  input  logic                               in_last_in,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [cpa_pkg::PHASE_W-1:0] out_phase,
  input  logic                               out_last_out,
  output int                                 mismatch_count,
  output int                                 beats_in_flight
);

  localparam int PW = cpa_pkg::PHASE_W;

  // Half a turn in binary angle units and pi scaled by 2^29.
  localparam longint BRAD_HALF  = 64'sd2147483648;
  localparam longint PI_SCALED  = 64'sd1686629713;

  typedef struct packed {
    logic signed [PW-1:0] phase;
    logic                 last;
  } phase_beat_t;

  // Micro-rotation angles atan(2^-i), binary angle units, rounded to nearest.
  logic [31:0] atan_brad [0:31] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

  phase_beat_t phase_expected_q[$];
  int          mismatch_total = 0;

  // Vectoring CORDIC on exact integers, then conversion to radians.
  function automatic phase_beat_t predict_phase(input logic signed [SAMPLE_WIDTH-1:0] re,
                                                input logic signed [SAMPLE_WIDTH-1:0] im,
                                                input logic last);
    longint      x;
    longint      y;
    longint      z;
    longint      xs;
    longint      ys;
    longint      prod;
    int          nstage;
    int          i;
    phase_beat_t beat;
    x = re;
    y = im;
    z = 0;
    beat.phase = '0;
    beat.last = last;
    nstage = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    if (x != 0 || y != 0) begin
      // Left half-plane: turn by pi first.
      if (x < 0) begin
        z = (y >= 0) ? BRAD_HALF : -BRAD_HALF;
        x = -x;
        y = -y;
      end
      for (i = 0; i < nstage; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(atan_brad[i]);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(atan_brad[i]);
        end
      end
      // Keep the residual inside -pi..pi.
      if (z > BRAD_HALF) z = BRAD_HALF;
      if (z < -BRAD_HALF) z = -BRAD_HALF;
      prod = z * PI_SCALED;
      prod = (prod + (64'sd1 <<< (59 - ANGLE_FRAC_BITS))) >>> (60 - ANGLE_FRAC_BITS);
      beat.phase = prod[PW-1:0];
    end
    return beat;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_total++;
  endtask

  // Push a prediction per accepted sample, pop and compare per result beat.
  always @(posedge clk) begin
    phase_beat_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        phase_expected_q.push_back(predict_phase(in_sample_re, in_sample_im, in_last_in));
      end
      if (out_valid && out_ready) begin
        if (phase_expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected, phase %0d",
                                    out_phase));
        end else begin
          want = phase_expected_q.pop_front();
          if (out_phase !== want.phase) begin
            report_mismatch($sformatf("phase %0d, expected %0d", out_phase, want.phase));
          end
          if (out_last_out !== want.last) begin
            report_mismatch($sformatf("last_out %b, expected %b", out_last_out, want.last));
          end
        end
      end
    end
    beats_in_flight <= phase_expected_q.size();
    mismatch_count <= mismatch_total;
  end

endmodule

### tb/tb_complex_phase_angle.sv
// Drives samples into the phase angle block under changing idle patterns
// and gives the verdict from the checker's mismatch count.
module tb_complex_phase_angle;

  localparam int SW           = cpa_pkg::SAMPLE_WIDTH_DEF;
  localparam int STAGES       = cpa_pkg::CORDIC_STAGES_DEF;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 300;
  localparam int BURST_BEATS  = 80;
  localparam int RANDOM_BEATS = 270;

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic signed [SW-1:0]               in_sample_re;
  logic signed [SW-1:0]               in_sample_im;
  logic                               in_last_in;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [cpa_pkg::PHASE_W-1:0] out_phase;
  logic                               out_last_out;

  int mismatch_count;
  int beats_in_flight;
  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  complex_phase_angle i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_re (in_sample_re),
    .in_sample_im (in_sample_im),
    .in_last_in   (in_last_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_phase    (out_phase),
    .out_last_out (out_last_out)
  );

  cpa_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_re    (in_sample_re),
    .in_sample_im    (in_sample_im),
    .in_last_in      (in_last_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_phase       (out_phase),
    .out_last_out    (out_last_out),
    .mismatch_count  (mismatch_count),
    .beats_in_flight (beats_in_flight)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one beat, after a random gap unless in a burst, and wait until it is taken.
  task automatic send_sample(input logic signed [SW-1:0] re, input logic signed [SW-1:0] im,
                             input logic last, input bit burst);
    int gap;
    gap = 0;
    if (!burst) begin
      while ($urandom_range(99) < sender_idle_pct && gap < 20) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_re <= re;
    in_sample_im <= im;
    in_last_in   <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly full-range samples, some near the origin and some on an axis.
  task automatic send_random(input int count, input bit burst);
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    int                   pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      re = SW'($urandom);
      im = SW'($urandom);
      if (pick >= 85) begin
        if ($urandom_range(1) == 1) re = '0;
        else im = '0;
      end else if (pick >= 70) begin
        re = SW'($urandom_range(16)) - SW'(8);
        im = SW'($urandom_range(16)) - SW'(8);
      end
      send_sample(re, im, 1'($urandom_range(1)), burst);
    end
  endtask

  // Stop offering and wait until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (beats_in_flight != 0);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_re = '0;
    in_sample_im = '0;
    in_last_in   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners: origin, axes, extremes and the negative real axis.
    send_sample(16'sd0, 16'sd0, 1'b0, 1'b0);
    send_sample(16'sd32767, 16'sd0, 1'b1, 1'b0);
    send_sample(-16'sd32768, 16'sd0, 1'b0, 1'b0);
    send_sample(-16'sd1, 16'sd0, 1'b1, 1'b0);
    send_sample(-16'sd5, 16'sd0, 1'b0, 1'b0);
    send_sample(-16'sd32768, -16'sd1, 1'b1, 1'b0);
    send_sample(-16'sd32768, 16'sd1, 1'b0, 1'b0);
    send_sample(16'sd0, 16'sd32767, 1'b1, 1'b0);
    send_sample(16'sd0, -16'sd32768, 1'b0, 1'b0);
    send_sample(16'sd0, 16'sd1, 1'b1, 1'b0);
    send_sample(16'sd0, -16'sd1, 1'b0, 1'b0);
    send_sample(16'sd1, 16'sd0, 1'b1, 1'b0);
    send_sample(16'sd32767, 16'sd32767, 1'b0, 1'b0);
    send_sample(-16'sd32768, -16'sd32768, 1'b1, 1'b0);
    send_sample(-16'sd32768, 16'sd32767, 1'b0, 1'b0);
    send_sample(16'sd32767, -16'sd32768, 1'b1, 1'b0);
    send_sample(-16'sd1, -16'sd1, 1'b0, 1'b0);
    send_sample(-16'sd1, 16'sd1, 1'b1, 1'b0);
    send_sample(16'sd1, -16'sd1, 1'b0, 1'b0);
    send_sample(-16'sd21846, 16'sd21845, 1'b1, 1'b0);
    wait_drained();

    // Receiver stalls more than the sender idles, then the other way round.
    sender_idle_pct = 33;
    recv_idle_pct <= 56;
    send_random(RANDOM_BEATS, 1'b0);
    wait_drained();
    sender_idle_pct = 56;
    recv_idle_pct <= 33;
    send_random(RANDOM_BEATS, 1'b0);
    wait_drained();

    // No idling; a long receiver hold-off fills the pipeline first.
    sender_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_seq <= hold_seq + 1;
    send_random(BURST_BEATS, 1'b1);
    send_random(RANDOM_BEATS, 1'b0);

    // Drain, let the pipeline empty, then decide.
    wait_drained();
    repeat (STAGES + 8) @(posedge clk);
    if (mismatch_count == 0 && beats_in_flight == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
